FILE: rtl/core/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types and token ids for the token block pattern classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpc_pkg;

	localparam int BLOCK_TOKENS = 6;
	localparam int TOKEN_BITS   = 18;
	localparam int CNT_W        = 3;
	localparam int IDX_W        = $clog2(BLOCK_TOKENS);

	localparam logic [TOKEN_BITS-1:0] ID_BOX_START = TOKEN_BITS'(151668);
	localparam logic [TOKEN_BITS-1:0] ID_BOX_END   = TOKEN_BITS'(151669);
	localparam logic [TOKEN_BITS-1:0] ID_COORD_LO  = TOKEN_BITS'(151677);
	localparam logic [TOKEN_BITS-1:0] ID_COORD_HI  = TOKEN_BITS'(152677);
	localparam logic [TOKEN_BITS-1:0] ID_REF_END   = TOKEN_BITS'(151673);
	localparam logic [TOKEN_BITS-1:0] ID_NONE      = TOKEN_BITS'(4064);
	localparam logic [TOKEN_BITS-1:0] ID_NULL      = TOKEN_BITS'(152678);
	localparam logic [TOKEN_BITS-1:0] ID_IM_END    = TOKEN_BITS'(151645);

	localparam logic OP_BLOCK  = 1'b0;
	localparam logic OP_SINGLE = 1'b1;

	localparam logic REG_FAST_MODE = 1'b0;

	typedef logic [TOKEN_BITS-1:0] token_t;

	typedef enum logic [2:0] {
		TYPE_END          = 3'd0,
		TYPE_EMPTY_BOX    = 3'd1,
		TYPE_COORD_BOX    = 3'd2,
		TYPE_POINT_BOX    = 3'd3,
		TYPE_ERROR_BOX    = 3'd4,
		TYPE_REF_OBJECT   = 3'd5,
		TYPE_BOX_END_SGL  = 3'd6,
		TYPE_COORD_SGL    = 3'd7
	} type_code_t;

	// per-token match flags produced by one lane
	typedef struct packed {
		logic in_coord;
		logic is_null;
		logic is_im_end;
		logic is_box_start;
		logic is_box_end;
		logic is_none;
		logic is_ref_end;
	} lane_flags_t;

	typedef struct packed {
		type_code_t           type_code;
		logic [CNT_W-1:0]     commit_count;
		token_t [BLOCK_TOKENS-1:0] commit;
		logic                 set_done;
		logic                 set_mtp;
		logic                 clr_mtp;
	} merge_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/tbpc_lane.sv
// ----------------------------------------------------------------------------
// tbpc_lane
// Matches one token id against the special ids and the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpc_lane
	import tbpc_pkg::*;
(
	input  wire token_t  token,
	output lane_flags_t flags
);

	always_comb begin
		flags.in_coord     = (token >= ID_COORD_LO) && (token <= ID_COORD_HI);
		flags.is_null      = (token == ID_NULL);
		flags.is_im_end    = (token == ID_IM_END);
		flags.is_box_start = (token == ID_BOX_START);
		flags.is_box_end   = (token == ID_BOX_END);
		flags.is_none      = (token == ID_NONE);
		flags.is_ref_end   = (token == ID_REF_END);
	end

endmodule

`default_nettype wire

FILE: rtl/core/tbpc_merge.sv
// ----------------------------------------------------------------------------
// tbpc_merge
// Combines the lane flags of one item into its class and committed tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpc_merge
	import tbpc_pkg::*;
(
	input  wire logic                      operation,
	input  wire logic [CNT_W-1:0]          count,
	input  wire token_t [BLOCK_TOKENS-1:0] tok,
	input  wire lane_flags_t [BLOCK_TOKENS-1:0] fl,
	input  wire logic                      fast_mode,
	output merge_result_t                  res
);

	logic [CNT_W-1:0] k_box;
	logic [CNT_W-1:0] k_ref;
	logic [CNT_W-1:0] k_ref_fix;
	logic [CNT_W-1:0] cnt;
	logic             run;
	logic             found;
	type_code_t       tc;

	// leading coordinate run after box-start, bounded by four and by count
	always_comb begin
		k_box = CNT_W'(1);
		run   = 1'b1;
		for (int i = 1; i < 5; i++) begin
			run = run && fl[i].in_coord && (CNT_W'(i) < count);
			if (run)
				k_box = CNT_W'(i + 1);
		end
	end

	// reference object: cut at first null, then collapse a doubled ref-end
	always_comb begin
		k_ref = count;
		found = 1'b0;
		for (int i = 0; i < BLOCK_TOKENS; i++) begin
			if (!found && (CNT_W'(i) < count) && fl[i].is_null) begin
				k_ref = CNT_W'(i);
				found = 1'b1;
			end
		end
		k_ref_fix = k_ref;
		if (k_ref >= CNT_W'(2)) begin
			if (fl[IDX_W'(k_ref - CNT_W'(1))].is_ref_end &&
			    fl[IDX_W'(k_ref - CNT_W'(2))].is_ref_end)
				k_ref_fix = k_ref - CNT_W'(1);
		end
	end

	always_comb begin
		res.set_done = 1'b0;
		res.set_mtp  = 1'b0;
		res.clr_mtp  = 1'b0;
		tc           = TYPE_END;
		cnt          = CNT_W'(1);
		if (operation == OP_SINGLE) begin
			if (fl[0].is_box_end) begin
				tc          = TYPE_BOX_END_SGL;
				res.set_mtp = 1'b1;
			end else if (fl[0].in_coord || fl[0].is_none) begin
				tc = TYPE_COORD_SGL;
			end else begin
				tc           = TYPE_END;
				res.set_done = 1'b1;
			end
		end else if (count == '0 || fl[0].is_null || fl[0].is_im_end) begin
			tc           = TYPE_END;
			res.set_done = 1'b1;
		end else if (count >= CNT_W'(2) && fl[0].is_box_start && fl[1].is_none) begin
			tc  = TYPE_EMPTY_BOX;
			cnt = CNT_W'(3);
		end else if (fl[0].is_box_start) begin
			if (k_box == CNT_W'(5) && count == CNT_W'(BLOCK_TOKENS) && fl[5].is_box_end) begin
				tc  = TYPE_COORD_BOX;
				cnt = count;
			end else if (k_box == CNT_W'(3) && count >= CNT_W'(4) && fl[3].is_box_end) begin
				tc  = TYPE_POINT_BOX;
				cnt = CNT_W'(4);
			end else if (fast_mode) begin
				tc  = TYPE_COORD_BOX;
				cnt = count;
			end else begin
				tc          = TYPE_ERROR_BOX;
				cnt         = k_box;
				res.clr_mtp = 1'b1;
			end
		end else begin
			tc  = TYPE_REF_OBJECT;
			cnt = k_ref_fix;
		end
		res.type_code    = tc;
		res.commit_count = cnt;

		for (int i = 0; i < BLOCK_TOKENS; i++)
			res.commit[i] = (CNT_W'(i) < cnt) ? tok[i] : '0;
		if (operation == OP_BLOCK && tc == TYPE_END) begin
			res.commit[0] = ID_IM_END;
		end else if (operation == OP_BLOCK && tc == TYPE_EMPTY_BOX) begin
			res.commit[0] = ID_BOX_START;
			res.commit[1] = ID_NONE;
			res.commit[2] = ID_BOX_END;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/token_block_pattern_classifier.sv
// ----------------------------------------------------------------------------
// token_block_pattern_classifier
// Classifies token blocks or single tokens and emits the committed tokens.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_ready    operation, token_count, tok0..tok5
//  out       out_valid/out_ready  type_code, commit_count, commit0..5, ended, in_mtp
//  cfg       APB (psel/penable)   fast_mode at byte address 0
//
// One item per cycle sustained; each item passes the lane match stage, then
// the merge into the output register.
// Both stages stall together while the output is held.
// Reset clears fast_mode, sets multi-token mode, clears the terminated flag.
// ----------------------------------------------------------------------------
`default_nettype none

module token_block_pattern_classifier
	import tbpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [2:0]  token_count,
	input  wire token_t      tok0,
	input  wire token_t      tok1,
	input  wire token_t      tok2,
	input  wire token_t      tok3,
	input  wire token_t      tok4,
	input  wire token_t      tok5,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       type_code,
	output logic [2:0]       commit_count,
	output token_t           commit0,
	output token_t           commit1,
	output token_t           commit2,
	output token_t           commit3,
	output token_t           commit4,
	output token_t           commit5,
	output logic             ended,
	output logic             in_mtp,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	token_t [BLOCK_TOKENS-1:0]      tok_in;
	lane_flags_t [BLOCK_TOKENS-1:0] flags;
	token_t [BLOCK_TOKENS-1:0]      tok_s1;
	lane_flags_t [BLOCK_TOKENS-1:0] flags_s1;
	logic                           op_s1;
	logic [CNT_W-1:0]               cnt_s1;
	logic                           valid_s1;
	logic [CNT_W-1:0]               cnt_sat;
	merge_result_t                  res;
	logic                           advance;
	logic                           fast_q;
	logic                           mtp_q;
	logic                           done_q;
	logic                           mtp_next;
	logic                           done_next;
	type_code_t                     type_q;
	logic [CNT_W-1:0]               count_q;
	token_t [BLOCK_TOKENS-1:0]      commit_q;

	assign tok_in  = {tok5, tok4, tok3, tok2, tok1, tok0};
	assign cnt_sat = (token_count > CNT_W'(BLOCK_TOKENS)) ? CNT_W'(BLOCK_TOKENS) : token_count;

	for (genvar g = 0; g < BLOCK_TOKENS; g++) begin : g_lane
		tbpc_lane u_lane (
			.token (tok_in[g]),
			.flags (flags[g])
		);
	end

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			tok_s1   <= tok_in;
			flags_s1 <= flags;
			op_s1    <= operation;
			cnt_s1   <= cnt_sat;
		end
	end

	tbpc_merge u_merge (
		.operation (op_s1),
		.count     (cnt_s1),
		.tok       (tok_s1),
		.fl        (flags_s1),
		.fast_mode (fast_q),
		.res       (res)
	);

	assign done_next = done_q | res.set_done;
	assign mtp_next  = res.set_mtp ? 1'b1 : (res.clr_mtp ? 1'b0 : mtp_q);

	// flags update as the merged result is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			mtp_q     <= 1'b1;
			done_q    <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				mtp_q  <= mtp_next;
				done_q <= done_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			type_q   <= res.type_code;
			count_q  <= res.commit_count;
			commit_q <= res.commit;
		end
	end

	assign type_code    = type_q;
	assign commit_count = count_q;
	assign commit0      = commit_q[0];
	assign commit1      = commit_q[1];
	assign commit2      = commit_q[2];
	assign commit3      = commit_q[3];
	assign commit4      = commit_q[4];
	assign commit5      = commit_q[5];
	assign ended        = done_q;
	assign in_mtp       = mtp_q;

	// configuration: word index in paddr[2], byte offset ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAST_MODE) begin
			fast_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FAST_MODE) ? {31'b0, fast_q} : 32'b0;

	// terminated flag is sticky across results
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && ended) |=> (!out_valid || ended))
		else $error("terminated flag cleared");

	// an error box always leaves multi-token mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && type_code == TYPE_ERROR_BOX) |-> !in_mtp)
		else $error("error box kept multi-token mode");

	// a single box-end always restores multi-token mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && type_code == TYPE_BOX_END_SGL) |-> in_mtp)
		else $error("box end did not restore multi-token mode");

	// an end result always terminates
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && type_code == TYPE_END) |-> (ended && commit_count == CNT_W'(1)))
		else $error("end result without termination");

endmodule

`default_nettype wire
